@@ design/pst_pkg.sv @@
// Package: shared constants, types and box test for the proximity set tracker.
`timescale 1ns / 1ps
package pst_pkg;

  localparam int MAX_OBJECTS = 32;
  localparam int COORD_BITS  = 16;
  localparam int ID_W        = 16;
  localparam int RAD_W       = 16;
  localparam int KIND_W      = 3;
  localparam int REQ_W       = 2;
  localparam int IDX_W       = $clog2(MAX_OBJECTS);
  localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
  localparam int BOX_W       = ((COORD_BITS > RAD_W) ? COORD_BITS : RAD_W) + 2;

  localparam logic [REQ_W-1:0] REQ_ENTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEAVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MOVE  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ENTER  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LEAVE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MOVING = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]              id;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [RAD_W-1:0]             r;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MELATCH,
    ST_SCAN,
    ST_FINISH,
    ST_REJECT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic lookup;
    logic latch_me;
    logic scan;
    logic finish;
    logic reject;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic scan_done;
    logic out_free;
  } sts_t;

  function automatic logic [IDX_W-1:0] find_first(input logic [MAX_OBJECTS-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_OBJECTS - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic in_box(input logic signed [COORD_BITS-1:0] px,
                                  input logic signed [COORD_BITS-1:0] py,
                                  input logic signed [COORD_BITS-1:0] cx,
                                  input logic signed [COORD_BITS-1:0] cy,
                                  input logic [RAD_W-1:0] r);
    logic signed [BOX_W-1:0] dx;
    logic signed [BOX_W-1:0] dy;
    logic signed [BOX_W-1:0] rr;
    dx = BOX_W'(px) - BOX_W'(cx);
    dy = BOX_W'(py) - BOX_W'(cy);
    rr = BOX_W'(signed'({1'b0, r}));
    return (dx <= rr) && (dx >= -rr) && (dy <= rr) && (dy >= -rr);
  endfunction

endpackage

@@ design/proximity_set_tracker_top.sv @@
// Top level: proximity set tracker, controller plus datapath.
//
//  channel | direction | handshake            | payload
//  request | in        | in_valid_i/in_ready_o| req_type, obj_id, pos_x, pos_y, view_radius
//  result  | out       | out_valid_o/out_ready_i | event_kind, other_id, other_x, other_y, last
//
// A request passes through lookup, the acting-slot read, one table slot read per scan cycle,
// the drain of the scan pipeline, commit and the return to idle; a rejected request passes
// through lookup and the reject state. The scan stalls while the sink holds back a result
// beat and another hit waits; commit and reject wait for the output register to be free.
// No clearing pass: slot valid flags reset at once. One request at a time; the
// next is taken while the last beat of the previous still waits in the output register.
`timescale 1ns / 1ps
module proximity_set_tracker_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [pst_pkg::REQ_W-1:0]             req_type_i,
  input  logic [pst_pkg::ID_W-1:0]              obj_id_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [pst_pkg::RAD_W-1:0]             view_radius_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pst_pkg::KIND_W-1:0]            event_kind_o,
  output logic [pst_pkg::ID_W-1:0]              other_id_o,
  output logic signed [pst_pkg::COORD_BITS-1:0] other_x_o,
  output logic signed [pst_pkg::COORD_BITS-1:0] other_y_o,
  output logic                                  last_o
);

  pst_pkg::cmd_t cmd;
  pst_pkg::sts_t sts;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pst_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .obj_id_i      (obj_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .view_radius_i (view_radius_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .other_id_o    (other_id_o),
    .other_x_o     (other_x_o),
    .other_y_o     (other_y_o),
    .last_o        (last_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one in progress");

  a_single_beat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == pst_pkg::KIND_DONE ||
                    event_kind_o == pst_pkg::KIND_REJECT) |-> last_o)
    else $error("done or rejected beat without last");

  a_single_beat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == pst_pkg::KIND_DONE ||
                    event_kind_o == pst_pkg::KIND_REJECT) |-> other_id_o == '0)
    else $error("done or rejected beat with non-zero id");

endmodule

@@ design/pst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pst_ctrl.sv @@
// Controller state machine: request sequencing over lookup, scan and commit, or reject.
`timescale 1ns / 1ps
module pst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pst_pkg::sts_t     sts_i,
  output pst_pkg::cmd_t     cmd_o
);

  pst_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pst_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pst_pkg::ST_LOOKUP;
        end
      end
      pst_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d = sts_i.bad ? pst_pkg::ST_REJECT : pst_pkg::ST_MELATCH;
      end
      pst_pkg::ST_MELATCH: begin
        cmd_o.latch_me = 1'b1;
        state_d = pst_pkg::ST_SCAN;
      end
      pst_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = pst_pkg::ST_FINISH;
      end
      pst_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) state_d = pst_pkg::ST_IDLE;
      end
      pst_pkg::ST_REJECT: begin
        cmd_o.reject = 1'b1;
        if (sts_i.out_free) state_d = pst_pkg::ST_IDLE;
      end
      default: state_d = pst_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/pst_dpath.sv @@
// Datapath: slot table, scan pipeline, pending result and output register.
`timescale 1ns / 1ps
module pst_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pst_pkg::cmd_t                         cmd_i,
  output pst_pkg::sts_t                         sts_o,
  input  logic [pst_pkg::REQ_W-1:0]             req_type_i,
  input  logic [pst_pkg::ID_W-1:0]              obj_id_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [pst_pkg::RAD_W-1:0]             view_radius_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pst_pkg::KIND_W-1:0]            event_kind_o,
  output logic [pst_pkg::ID_W-1:0]              other_id_o,
  output logic signed [pst_pkg::COORD_BITS-1:0] other_x_o,
  output logic signed [pst_pkg::COORD_BITS-1:0] other_y_o,
  output logic                                  last_o
);

  localparam int N = pst_pkg::MAX_OBJECTS;

  // request
  logic [pst_pkg::REQ_W-1:0]             req_q;
  logic [pst_pkg::ID_W-1:0]              id_q;
  logic signed [pst_pkg::COORD_BITS-1:0] nx_q, ny_q;
  logic [pst_pkg::RAD_W-1:0]             rad_q;
  logic [N-1:0]                          match_q, match_d;

  // acting slot
  logic [pst_pkg::IDX_W-1:0]             me_idx_q, free_idx_q, match_idx, free_idx;
  logic signed [pst_pkg::COORD_BITS-1:0] me_x_q, me_y_q;
  logic [pst_pkg::RAD_W-1:0]             me_r_q;

  // table
  logic [N-1:0]                          slot_valid_q, slot_valid_d;
  logic [pst_pkg::ID_W-1:0]              slot_id_q [N];

  // scan
  logic [pst_pkg::CNT_W-1:0]             cnt_q;
  logic                                  s1_v_q;
  logic [pst_pkg::IDX_W-1:0]             s1_idx_q;

  // pending result
  logic                                  pend_v_q;
  logic [pst_pkg::KIND_W-1:0]            pend_kind_q;
  logic [pst_pkg::ID_W-1:0]              pend_id_q;
  logic signed [pst_pkg::COORD_BITS-1:0] pend_x_q, pend_y_q;

  // output
  logic                                  out_v_q, out_v_d;
  logic [pst_pkg::KIND_W-1:0]            out_kind_q, out_kind_d;
  logic [pst_pkg::ID_W-1:0]              out_id_q, out_id_d;
  logic signed [pst_pkg::COORD_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic                                  out_last_q, out_last_d;
  logic                                  out_load;

  // RAM
  logic                                  ram_re, ram_we;
  logic [pst_pkg::IDX_W-1:0]             ram_raddr, ram_waddr;
  pst_pkg::slot_t                        ram_wdata, rd;
  logic [$bits(pst_pkg::slot_t)-1:0]     ram_rdata;

  logic                                  out_free, in_a, in_b, elig, hit, stall, advance;
  logic                                  re_scan, take, commit, bad, scan_done;
  logic [pst_pkg::KIND_W-1:0]            hit_kind;
  logic signed [pst_pkg::COORD_BITS-1:0] ax, ay;
  logic [pst_pkg::RAD_W-1:0]             ar;

  pst_ram #(
    .WIDTH ($bits(pst_pkg::slot_t)),
    .DEPTH (N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = ram_rdata;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_d[i] = slot_valid_q[i] && (slot_id_q[i] == obj_id_i);
    end
  end

  assign match_idx = pst_pkg::find_first(match_q);
  assign free_idx  = pst_pkg::find_first(~slot_valid_q);
  assign out_free  = !out_v_q || out_ready_i;

  always_comb begin
    case (req_q)
      pst_pkg::REQ_ENTER: bad = (|match_q) || (&slot_valid_q);
      pst_pkg::REQ_LEAVE,
      pst_pkg::REQ_MOVE:  bad = ~(|match_q);
      default:            bad = 1'b1;
    endcase
  end
  assign scan_done = (cnt_q == pst_pkg::CNT_W'(N)) && !s1_v_q;
  assign sts_o     = '{bad: bad, scan_done: scan_done, out_free: out_free};

  // box tests on the slot in flight
  assign ax   = (req_q == pst_pkg::REQ_ENTER) ? nx_q  : me_x_q;
  assign ay   = (req_q == pst_pkg::REQ_ENTER) ? ny_q  : me_y_q;
  assign ar   = (req_q == pst_pkg::REQ_ENTER) ? rad_q : me_r_q;
  assign in_a = pst_pkg::in_box(rd.x, rd.y, ax, ay, ar);
  assign in_b = pst_pkg::in_box(rd.x, rd.y, nx_q, ny_q, me_r_q);
  assign elig = s1_v_q && slot_valid_q[s1_idx_q] &&
                !((req_q != pst_pkg::REQ_ENTER) && (s1_idx_q == me_idx_q));

  always_comb begin
    hit_kind = pst_pkg::KIND_ENTER;
    case (req_q)
      pst_pkg::REQ_ENTER: begin
        hit      = in_a;
        hit_kind = pst_pkg::KIND_ENTER;
      end
      pst_pkg::REQ_LEAVE: begin
        hit      = in_a;
        hit_kind = pst_pkg::KIND_LEAVE;
      end
      pst_pkg::REQ_MOVE: begin
        hit = in_a || in_b;
        if (in_a && in_b) hit_kind = pst_pkg::KIND_MOVING;
        else if (in_a)    hit_kind = pst_pkg::KIND_LEAVE;
        else              hit_kind = pst_pkg::KIND_ENTER;
      end
      default: hit = 1'b0;
    endcase
    hit = hit && elig;
  end

  assign stall   = cmd_i.scan && hit && pend_v_q && !out_free;
  assign advance = cmd_i.scan && !stall;
  assign re_scan = advance && (cnt_q < pst_pkg::CNT_W'(N));
  assign take    = advance && hit;
  assign commit  = cmd_i.finish && out_free;

  assign ram_re    = cmd_i.lookup || re_scan;
  assign ram_raddr = cmd_i.lookup ? match_idx : cnt_q[pst_pkg::IDX_W-1:0];

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = me_idx_q;
    ram_wdata    = '{id: id_q, x: nx_q, y: ny_q, r: me_r_q};
    slot_valid_d = slot_valid_q;
    if (commit) begin
      case (req_q)
        pst_pkg::REQ_ENTER: begin
          ram_we       = 1'b1;
          ram_waddr    = free_idx_q;
          ram_wdata.r  = rad_q;
          slot_valid_d[free_idx_q] = 1'b1;
        end
        pst_pkg::REQ_LEAVE: slot_valid_d[me_idx_q] = 1'b0;
        pst_pkg::REQ_MOVE:  ram_we = 1'b1;
        default: ;
      endcase
    end
  end

  // output beat selection
  always_comb begin
    out_load   = 1'b0;
    out_kind_d = pend_kind_q;
    out_id_d   = pend_id_q;
    out_x_d    = pend_x_q;
    out_y_d    = pend_y_q;
    out_last_d = 1'b0;
    if (take && pend_v_q) begin
      out_load = 1'b1;
    end else if (commit) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
      if (!pend_v_q) begin
        out_kind_d = pst_pkg::KIND_DONE;
        out_id_d   = '0;
        out_x_d    = '0;
        out_y_d    = '0;
      end
    end else if (cmd_i.reject && out_free) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
      out_kind_d = pst_pkg::KIND_REJECT;
      out_id_d   = '0;
      out_x_d    = '0;
      out_y_d    = '0;
    end
    if (out_load)         out_v_d = 1'b1;
    else if (out_ready_i) out_v_d = 1'b0;
    else                  out_v_d = out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      out_v_q      <= 1'b0;
      pend_v_q     <= 1'b0;
      s1_v_q       <= 1'b0;
      cnt_q        <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
      out_v_q      <= out_v_d;
      if (cmd_i.latch_me) begin
        pend_v_q <= 1'b0;
        s1_v_q   <= 1'b0;
        cnt_q    <= '0;
      end else begin
        if (take) pend_v_q <= 1'b1;
        if (advance) s1_v_q <= re_scan;
        if (re_scan) cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      id_q    <= obj_id_i;
      nx_q    <= pos_x_i;
      ny_q    <= pos_y_i;
      rad_q   <= view_radius_i;
      match_q <= match_d;
    end
    if (cmd_i.lookup) begin
      me_idx_q   <= match_idx;
      free_idx_q <= free_idx;
    end
    if (cmd_i.latch_me) begin
      me_x_q <= rd.x;
      me_y_q <= rd.y;
      me_r_q <= rd.r;
    end
    if (re_scan) s1_idx_q <= cnt_q[pst_pkg::IDX_W-1:0];
    if (take) begin
      pend_kind_q <= hit_kind;
      pend_id_q   <= rd.id;
      pend_x_q    <= rd.x;
      pend_y_q    <= rd.y;
    end
    if (commit && (req_q == pst_pkg::REQ_ENTER)) slot_id_q[free_idx_q] <= id_q;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign event_kind_o = out_kind_q;
  assign other_id_o   = out_id_q;
  assign other_x_o    = out_x_q;
  assign other_y_o    = out_y_q;
  assign last_o       = out_last_q;

endmodule

@@ tb/pst_checker.sv @@
// Checker: watches request and result beats, predicts the tracker's results and compares them.
`timescale 1ns / 1ps
module pst_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [pst_pkg::REQ_W-1:0]             req_type_i,
  input  logic [pst_pkg::ID_W-1:0]              obj_id_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [pst_pkg::RAD_W-1:0]             view_radius_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic [pst_pkg::KIND_W-1:0]            event_kind_i,
  input  logic [pst_pkg::ID_W-1:0]              other_id_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] other_x_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] other_y_i,
  input  logic                                  last_i,
  output int                                    errors_o,
  output int                                    pending_o
);

  typedef struct packed {
    logic [pst_pkg::KIND_W-1:0]            kind;
    logic [pst_pkg::ID_W-1:0]              id;
    logic signed [pst_pkg::COORD_BITS-1:0] x;
    logic signed [pst_pkg::COORD_BITS-1:0] y;
    logic                                  last;
  } event_t;

  event_t    events_due[$];
  bit        tbl_used [pst_pkg::MAX_OBJECTS];
  logic [pst_pkg::ID_W-1:0]              tbl_id [pst_pkg::MAX_OBJECTS];
  logic signed [pst_pkg::COORD_BITS-1:0] tbl_x [pst_pkg::MAX_OBJECTS];
  logic signed [pst_pkg::COORD_BITS-1:0] tbl_y [pst_pkg::MAX_OBJECTS];
  logic [pst_pkg::RAD_W-1:0]             tbl_r [pst_pkg::MAX_OBJECTS];

  function automatic bit near(int s, longint cx, longint cy, longint r);
    longint dx, dy;
    dx = longint'(tbl_x[s]) - cx;
    dy = longint'(tbl_y[s]) - cy;
    return (dx <= r) && (dx >= -r) && (dy <= r) && (dy >= -r);
  endfunction

  function automatic void add_event(logic [pst_pkg::KIND_W-1:0] k, int s);
    event_t e;
    e.kind = k;
    e.id   = (s < 0) ? '0 : tbl_id[s];
    e.x    = (s < 0) ? '0 : tbl_x[s];
    e.y    = (s < 0) ? '0 : tbl_y[s];
    e.last = 1'b0;
    events_due.push_back(e);
  endfunction

  function automatic void predict_request(logic [pst_pkg::REQ_W-1:0] req,
                                          logic [pst_pkg::ID_W-1:0] id,
                                          logic signed [pst_pkg::COORD_BITS-1:0] nx,
                                          logic signed [pst_pkg::COORD_BITS-1:0] ny,
                                          logic [pst_pkg::RAD_W-1:0] rad);
    int me, free, n0;
    bit ok, was, now;
    me = -1; free = -1; ok = 0;
    n0 = events_due.size();
    for (int i = pst_pkg::MAX_OBJECTS - 1; i >= 0; i--) begin
      if (tbl_used[i] && tbl_id[i] == id) me = i;
      if (!tbl_used[i]) free = i;
    end
    if (req == pst_pkg::REQ_ENTER && me < 0 && free >= 0) begin
      ok = 1;
      for (int i = 0; i < pst_pkg::MAX_OBJECTS; i++)
        if (tbl_used[i] && near(i, nx, ny, rad)) add_event(pst_pkg::KIND_ENTER, i);
      tbl_used[free] = 1'b1;
      tbl_id[free] = id; tbl_x[free] = nx; tbl_y[free] = ny; tbl_r[free] = rad;
    end else if (req == pst_pkg::REQ_LEAVE && me >= 0) begin
      ok = 1;
      for (int i = 0; i < pst_pkg::MAX_OBJECTS; i++)
        if (i != me && tbl_used[i] && near(i, tbl_x[me], tbl_y[me], tbl_r[me]))
          add_event(pst_pkg::KIND_LEAVE, i);
      tbl_used[me] = 1'b0;
    end else if (req == pst_pkg::REQ_MOVE && me >= 0) begin
      ok = 1;
      for (int i = 0; i < pst_pkg::MAX_OBJECTS; i++) begin
        if (i == me || !tbl_used[i]) continue;
        was = near(i, tbl_x[me], tbl_y[me], tbl_r[me]);
        now = near(i, nx, ny, tbl_r[me]);
        if (was && now) add_event(pst_pkg::KIND_MOVING, i);
        else if (was)   add_event(pst_pkg::KIND_LEAVE, i);
        else if (now)   add_event(pst_pkg::KIND_ENTER, i);
      end
      tbl_x[me] = nx; tbl_y[me] = ny;
    end
    if (!ok) add_event(pst_pkg::KIND_REJECT, -1);
    else if (events_due.size() == n0) add_event(pst_pkg::KIND_DONE, -1);
    events_due[events_due.size() - 1].last = 1'b1;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t pst_checker: %s mismatch, got %0d want %0d", $time, what, got, want);
    errors_o++;
  endtask

  initial errors_o = 0;
  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    event_t e;
    if (!rst_ni) begin
      for (int i = 0; i < pst_pkg::MAX_OBJECTS; i++) tbl_used[i] = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (events_due.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          e = events_due.pop_front();
          if (event_kind_i !== e.kind) report("event_kind", event_kind_i, e.kind);
          if (other_id_i !== e.id)     report("other_id", other_id_i, e.id);
          if (other_x_i !== e.x)       report("other_x", other_x_i, e.x);
          if (other_y_i !== e.y)       report("other_y", other_y_i, e.y);
          if (last_i !== e.last)       report("last", last_i, e.last);
        end
      end
      if (in_valid_i && in_ready_i)
        predict_request(req_type_i, obj_id_i, pos_x_i, pos_y_i, view_radius_i);
    end
    pending_o = events_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: drives requests into the proximity set tracker and gives the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int N_RANDOM   = 273;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [pst_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [pst_pkg::REQ_W-1:0] req_type_i = '0;
  logic [pst_pkg::ID_W-1:0] obj_id_i = '0;
  logic signed [pst_pkg::COORD_BITS-1:0] pos_x_i = '0;
  logic signed [pst_pkg::COORD_BITS-1:0] pos_y_i = '0;
  logic [pst_pkg::RAD_W-1:0] view_radius_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [pst_pkg::KIND_W-1:0] event_kind_o;
  logic [pst_pkg::ID_W-1:0] other_id_o;
  logic signed [pst_pkg::COORD_BITS-1:0] other_x_o;
  logic signed [pst_pkg::COORD_BITS-1:0] other_y_o;
  logic last_o;
  int errors, pending;
  bit hold_off = 0;
  int idle_cycles = 0;
  logic [pst_pkg::ID_W-1:0] id_pool [8];

  always #2 clk_i = ~clk_i;

  proximity_set_tracker_top dut (.*);

  pst_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .obj_id_i,
    .pos_x_i, .pos_y_i, .view_radius_i, .out_valid_i(out_valid_o), .out_ready_i,
    .event_kind_i(event_kind_o), .other_id_i(other_id_o), .other_x_i(other_x_o),
    .other_y_i(other_y_o), .last_i(last_o), .errors_o(errors), .pending_o(pending)
  );

  task automatic send(logic [pst_pkg::REQ_W-1:0] rq, logic [pst_pkg::ID_W-1:0] id,
                      logic signed [pst_pkg::COORD_BITS-1:0] x,
                      logic signed [pst_pkg::COORD_BITS-1:0] y,
                      logic [pst_pkg::RAD_W-1:0] r);
    in_valid_i    <= 1'b1;
    req_type_i    <= rq;
    obj_id_i      <= id;
    pos_x_i       <= x;
    pos_y_i       <= y;
    view_radius_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'h8000 | 16'($urandom_range(0, 3));
      2: return 16'h7FFC | 16'($urandom_range(0, 3));
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // receiver: random stall pattern, quiet stretches, and one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if (($time / 1000) % 3 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    @(posedge clk_i);
    wait (rst_ni);
    repeat (150) @(posedge clk_i);
    hold_off = 1;
    repeat (400) @(posedge clk_i);
    hold_off = 0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int burst;
    logic [pst_pkg::REQ_W-1:0] rq;
    for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, duplicates, unknowns, unused type, full table
    send(pst_pkg::REQ_LEAVE, 16'h1234, 0, 0, 0);
    send(pst_pkg::REQ_MOVE, 16'h1234, 0, 0, 0);
    send(pst_pkg::REQ_ENTER, 16'h0000, 16'sh8000, 16'sh8000, 16'hFFFF);
    send(pst_pkg::REQ_ENTER, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    send(pst_pkg::REQ_ENTER, 16'h0000, 0, 0, 0);
    send(pst_pkg::REQ_ENTER, 16'h0001, 16'sh7FFF, 16'sh8000, 16'd0);
    send(pst_pkg::REQ_MOVE, 16'h0000, 16'sh7FFF, 16'sh7FFF, 0);
    send(pst_pkg::REQ_MOVE, 16'hFFFF, 16'sh8000, 16'sh7FFF, 0);
    send(REQ_UNUSED, 16'h0001, 0, 0, 0);
    send(pst_pkg::REQ_LEAVE, 16'hFFFF, 0, 0, 0);
    send(pst_pkg::REQ_LEAVE, 16'h0001, 0, 0, 0);
    send(pst_pkg::REQ_LEAVE, 16'h0000, 0, 0, 0);
    for (int i = 0; i < pst_pkg::MAX_OBJECTS + 1; i++)
      send(pst_pkg::REQ_ENTER, 16'(16'h0100 + i), 16'(i * 3), 16'(-i), 16'(i));
    for (int i = 0; i < pst_pkg::MAX_OBJECTS; i++)
      send(pst_pkg::REQ_LEAVE, 16'(16'h0100 + i), 0, 0, 0);
    // random: mostly ids from a small pool so moves and leaves find their target
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        rq = ($urandom_range(0, 19) == 0) ? REQ_UNUSED
                                          : pst_pkg::REQ_W'($urandom_range(0, 2));
        send(rq, ($urandom_range(0, 7) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)],
             coord(), coord(),
             ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)));
      end
      gap();
    end
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
